[hdl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg: shared definitions for the minimal set cover filter
// Word layouts, operation codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package msc_pkg;

    // Default sizes of the family store and the found store.
    localparam int MSC_MAX_ENTRIES = 32;
    localparam int MSC_MAX_FOUND   = 64;

    // Largest universe; member masks are 32 bits, so it never exceeds that.
    localparam int MSC_MAX_ELEMENTS = 32;
    localparam int MSC_UNI_LIMIT    = (MSC_MAX_ELEMENTS < 32) ? MSC_MAX_ELEMENTS : 32;

    // Register index of tree_count (byte address 4 * index).
    localparam logic MSC_REG_TREE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } msc_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UNION,
        ST_SUBSET,
        ST_FINISH
    } msc_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  entry_index;
        logic [31:0] entry_members;
        logic [31:0] candidate_mask;
    } msc_in_t;

    typedef struct packed {
        logic       covers;
        logic       accepted;
        logic       store_full;
        logic [6:0] found_total;
    } msc_out_t;

endpackage

[hdl/msc_ram.sv]
// ----------------------------------------------------------------------------
// msc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. No reset on the contents.
// ----------------------------------------------------------------------------
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/minimal_set_cover_filter.sv]
// ----------------------------------------------------------------------------
// minimal_set_cover_filter: candidate cover test against a stored family
// Holds a family of member masks, tests candidate selections for covering the
// universe and keeps the list of minimal covers found so far.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Word
//  in        input      in_valid / in_stall     msc_in_t  (op, index, members, mask)
//  out       output     out_valid / out_stall   msc_out_t (covers, accepted, full, total)
//  cfg       input      APB psel/penable/pwrite tree_count at byte address 0
//
// A load, clear or unused op goes straight to the finish state, which stalls the
// input and loads the output word. A test stalls the input through a union
// pass with one family store read per entry, a subset pass with one found
// store read per stored cover, and the finish state. An early hit cuts the
// subset pass short, and a candidate that misses the universe skips it.
// After reset the family store reads as all zeros through per-entry valid bits;
// no clearing pass is needed. The found store is only read below the count.
// A stalled output word holds; the next item is accepted while it waits, and
// its result waits in the finish state until the output register frees.
//
module minimal_set_cover_filter #(
    parameter int MAX_ENTRIES = msc_pkg::MSC_MAX_ENTRIES,
    parameter int MAX_FOUND   = msc_pkg::MSC_MAX_FOUND
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  msc_pkg::msc_in_t in_data,

    output logic             out_valid,
    input  logic             out_stall,
    output msc_pkg::msc_out_t out_data,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import msc_pkg::*;

    // Only 32 entries are reachable through a 5-bit index and a 32-bit mask.
    localparam int FAM_DEPTH = (MAX_ENTRIES < 32) ? MAX_ENTRIES : 32;
    localparam int FAM_AW    = (FAM_DEPTH > 1) ? $clog2(FAM_DEPTH) : 1;
    localparam int FOUND_AW  = (MAX_FOUND > 1) ? $clog2(MAX_FOUND) : 1;
    localparam int CNT_W     = $clog2(MAX_FOUND + 1);
    localparam int SCAN_MAX  = (FAM_DEPTH > MAX_FOUND) ? FAM_DEPTH : MAX_FOUND;
    localparam int SCAN_W    = $clog2(SCAN_MAX + 1);

    localparam logic [5:0]        FAM_DEPTH_IDX = 6'(FAM_DEPTH);
    localparam logic [SCAN_W-1:0] FAM_DEPTH_CNT = SCAN_W'(FAM_DEPTH);
    localparam logic [CNT_W-1:0]  FOUND_LIMIT   = CNT_W'(MAX_FOUND);
    localparam logic [5:0]        UNI_LIMIT     = 6'(MSC_UNI_LIMIT);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    msc_state_t          state_reg, state_next;
    logic [5:0]          tree_count_reg, tree_count_next;
    logic [FAM_DEPTH-1:0] fam_valid_reg, fam_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SCAN_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                sel_reg, sel_next;
    logic                hit_reg, hit_next;
    logic                covers_reg, covers_next;
    logic                accepted_reg, accepted_next;
    logic                full_reg, full_next;
    logic                out_valid_reg, out_valid_next;

    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         cand_reg, cand_next;
    logic [31:0]         cand_sh_reg, cand_sh_next;
    msc_out_t            out_data_reg, out_data_next;

    // RAM ports
    logic                fam_we;
    logic [FAM_AW-1:0]   fam_waddr;
    logic [FAM_AW-1:0]   fam_raddr;
    logic [31:0]         fam_rdata;
    logic                found_we;
    logic [FOUND_AW-1:0] found_waddr;
    logic [FOUND_AW-1:0] found_raddr;
    logic [31:0]         found_rdata;

    // Helpers
    logic                in_take;
    logic                out_free;
    logic                cfg_write;
    logic [5:0]          uni_bits;
    logic [32:0]         uni_wide;
    logic [31:0]         uni_mask;
    logic                scan_issue;
    logic [CNT_W+6:0]    total_wide;

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    msc_ram #(
        .WIDTH (32),
        .DEPTH (FAM_DEPTH),
        .AW    (FAM_AW)
    ) u_family (
        .clk   (clk),
        .we    (fam_we),
        .waddr (fam_waddr),
        .wdata (in_data.entry_members),
        .raddr (fam_raddr),
        .rdata (fam_rdata)
    );

    msc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_FOUND),
        .AW    (FOUND_AW)
    ) u_found (
        .clk   (clk),
        .we    (found_we),
        .waddr (found_waddr),
        .wdata (cand_reg),
        .raddr (found_raddr),
        .rdata (found_rdata)
    );

    // Both read ports follow the scan counter; only one pass runs at a time.
    assign fam_raddr   = idx_reg[FAM_AW-1:0];
    assign found_raddr = idx_reg[FOUND_AW-1:0];
    assign found_waddr = count_reg[FOUND_AW-1:0];
    assign fam_waddr   = in_data.entry_index[FAM_AW-1:0];

    // ------------------------------------------------------------------
    // Configuration port: tree_count is the only register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == MSC_REG_TREE_COUNT);
    assign prdata    = (paddr[2] == MSC_REG_TREE_COUNT) ? {26'd0, tree_count_reg} : 32'd0;

    always_comb
    begin
        tree_count_next = tree_count_reg;
        if (cfg_write)
        begin
            tree_count_next = pwdata[5:0];
        end
    end

    // The universe is the low tree_count bits, with the count saturated.
    assign uni_bits = (tree_count_reg > UNI_LIMIT) ? UNI_LIMIT : tree_count_reg;
    assign uni_wide = (33'd1 << uni_bits) - 33'd1;
    assign uni_mask = uni_wide[31:0];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign total_wide = {7'd0, count_reg};

    // ------------------------------------------------------------------
    // Sequencer. The union pass walks the family store one entry per cycle
    // and ORs in the selected words; the subset pass walks the found store
    // and stops early once a stored cover lies inside the candidate.
    // Reads land in the cycle after issue, so pend_reg marks a read in flight.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fam_valid_next = fam_valid_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        sel_next       = 1'b0;
        hit_next       = hit_reg;
        covers_next    = covers_reg;
        accepted_next  = accepted_reg;
        full_next      = full_reg;
        acc_next       = acc_reg;
        cand_next      = cand_reg;
        cand_sh_next   = cand_sh_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        fam_we         = 1'b0;
        found_we       = 1'b0;
        scan_issue     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    covers_next   = 1'b0;
                    accepted_next = 1'b0;
                    full_next     = 1'b0;
                    state_next    = ST_FINISH;
                    case (msc_op_t'(in_data.op))
                        OP_LOAD:
                        begin
                            if ({1'b0, in_data.entry_index} < FAM_DEPTH_IDX)
                            begin
                                fam_we = 1'b1;
                                fam_valid_next[fam_waddr] = 1'b1;
                            end
                        end
                        OP_TEST:
                        begin
                            cand_next    = in_data.candidate_mask;
                            cand_sh_next = in_data.candidate_mask;
                            acc_next     = 32'd0;
                            idx_next     = '0;
                            state_next   = ST_UNION;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_UNION:
            begin
                if (pend_reg && sel_reg)
                begin
                    acc_next = acc_reg | fam_rdata;
                end
                if (idx_reg != FAM_DEPTH_CNT)
                begin
                    pend_next    = 1'b1;
                    sel_next     = cand_sh_reg[0] && fam_valid_reg[fam_raddr];
                    cand_sh_next = {1'b0, cand_sh_reg[31:1]};
                    idx_next     = idx_reg + SCAN_W'(1);
                end
                else if (!pend_reg)
                begin
                    idx_next = '0;
                    hit_next = 1'b0;
                    if (acc_reg == uni_mask)
                    begin
                        covers_next = 1'b1;
                        state_next  = ST_SUBSET;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SUBSET:
            begin
                if (pend_reg && ((found_rdata & ~cand_reg) == 32'd0))
                begin
                    hit_next = 1'b1;
                end
                scan_issue = (idx_reg != SCAN_W'(count_reg)) && !hit_reg;
                if (scan_issue)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + SCAN_W'(1);
                end
                else if (!pend_reg)
                begin
                    if (!hit_reg)
                    begin
                        if (count_reg < FOUND_LIMIT)
                        begin
                            found_we      = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            accepted_next = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.covers      = covers_reg;
                    out_data_next.accepted    = accepted_reg;
                    out_data_next.store_full  = full_reg;
                    out_data_next.found_total = total_wide[6:0];
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg <= 6'd1;
            fam_valid_reg  <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            sel_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            covers_reg     <= 1'b0;
            accepted_reg   <= 1'b0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tree_count_reg <= tree_count_next;
            fam_valid_reg  <= fam_valid_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            sel_reg        <= sel_next;
            hit_reg        <= hit_next;
            covers_reg     <= covers_next;
            accepted_reg   <= accepted_next;
            full_reg       <= full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        cand_reg     <= cand_next;
        cand_sh_reg  <= cand_sh_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTH
    // The found store never holds more covers than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FOUND_LIMIT)
        else $error("found count beyond store size");

    // A cover that was stored or refused for lack of room must have covered,
    // and it cannot be both.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(out_data_reg.accepted && out_data_reg.store_full)
            && (!(out_data_reg.accepted || out_data_reg.store_full)
                || out_data_reg.covers)))
        else $error("inconsistent result flags");

    // A stored cover raises the count by exactly one at the next edge.
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        found_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("found store append without count step");

    // The union scan never runs past the family store.
    a_union_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNION) |-> (idx_reg <= FAM_DEPTH_CNT))
        else $error("union scan index out of range");
`endif

endmodule

[tb/minimal_set_cover_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_set_cover_filter_test: self-checking bench for the set cover filter
// Loads families of member masks, walks candidate selections in order of size
// and checks every result word against a cycle-free prediction of the filter,
// with random idling on both channels and tree_count rewritten between phases.
// ----------------------------------------------------------------------------
module minimal_set_cover_filter_test;
    import msc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 1150;
    // A test walks every family entry and at most every stored cover.
    localparam int SETTLE_CYCLES = 120;

    // Tracks the filter's state, predicts one result word per accepted input
    // word and compares the results in order of arrival.
    class cover_scoreboard;
        logic [5:0]  tree_count;
        logic [31:0] family_masks [MSC_MAX_ENTRIES];
        logic [31:0] found_masks [MSC_MAX_FOUND];
        int unsigned found_count;
        msc_out_t    pending [$];
        int unsigned mismatches;
        int unsigned tests_noted;
        int unsigned covers_noted;
        int unsigned stored_noted;
        int unsigned full_noted;
        int unsigned results_checked;

        function new();
            tree_count = 6'd1;
            found_count = 0;
            foreach (family_masks[i]) family_masks[i] = '0;
            foreach (found_masks[i]) found_masks[i] = '0;
            mismatches = 0;
            tests_noted = 0;
            covers_noted = 0;
            stored_noted = 0;
            full_noted = 0;
            results_checked = 0;
        endfunction

        function void set_tree_count(logic [5:0] value);
            tree_count = value;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        // The universe is the low tree_count bits, saturated to the mask width.
        function logic [31:0] universe_bits();
            int unsigned n;
            n = tree_count;
            if (n > MSC_UNI_LIMIT)
                n = MSC_UNI_LIMIT;
            if (n >= 32)
                return '1;
            return 32'((64'd1 << n) - 64'd1);
        endfunction

        function void note_word(msc_in_t w);
            msc_out_t    verdict;
            logic [31:0] union_bits;
            bit          holds_cover;
            int          k;
            verdict = '0;
            case (w.op)
                OP_LOAD:
                begin
                    if (w.entry_index < MSC_MAX_ENTRIES)
                        family_masks[w.entry_index] = w.entry_members;
                end
                OP_TEST:
                begin
                    tests_noted++;
                    union_bits = '0;
                    for (k = 0; k < 32 && k < MSC_MAX_ENTRIES; k++)
                        if (w.candidate_mask[k])
                            union_bits |= family_masks[k];
                    if (union_bits == universe_bits())
                    begin
                        verdict.covers = 1'b1;
                        covers_noted++;
                        // Any stored cover inside the candidate makes it non-minimal.
                        holds_cover = 1'b0;
                        for (k = 0; k < found_count && k < MSC_MAX_FOUND; k++)
                            if ((found_masks[k] & ~w.candidate_mask) == '0)
                                holds_cover = 1'b1;
                        if (!holds_cover)
                        begin
                            if (found_count < MSC_MAX_FOUND)
                            begin
                                found_masks[found_count] = w.candidate_mask;
                                found_count++;
                                verdict.accepted = 1'b1;
                                stored_noted++;
                            end
                            else
                            begin
                                verdict.store_full = 1'b1;
                                full_noted++;
                            end
                        end
                    end
                end
                OP_CLEAR: found_count = 0;
                default: ;
            endcase
            verdict.found_total = 7'(found_count);
            pending.insert(pending.size(), verdict);
        endfunction

        function void compare_field(string field, logic [6:0] want, logic [6:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(msc_out_t got);
            msc_out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word with none outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            results_checked++;
            compare_field("covers", 7'(want.covers), 7'(got.covers));
            compare_field("accepted", 7'(want.accepted), 7'(got.accepted));
            compare_field("store_full", 7'(want.store_full), 7'(got.store_full));
            compare_field("found_total", want.found_total, got.found_total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    msc_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    msc_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cover_scoreboard cover_tracker = new();
    int unsigned words_sent = 0;
    int unsigned config_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_percent = 0;
    bit          quiet = 1'b0;

    minimal_set_cover_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog ends a hung run; the limit is several times the slowest
    // legal run, where every test walks the full family and found store.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, cover_tracker.outstanding());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Every word leaving the filter is checked at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            cover_tracker.check_result(out_data);
    end

    // The result side stalls in bursts. The stall rate is redrawn now and then,
    // so that some stretches run with no stall at all, and it drops to zero for
    // the closing part of the run.
    initial
    begin
        int burst_left;
        int stall_percent;
        int rate_timer;
        burst_left = 0;
        stall_percent = 10;
        rate_timer = 0;
        forever
        begin
            @(negedge clk);
            rate_timer++;
            if (rate_timer >= 400)
            begin
                rate_timer = 0;
                case ($urandom_range(0, 3))
                    0: stall_percent = 0;
                    1: stall_percent = 10;
                    2: stall_percent = 30;
                    default: stall_percent = 60;
                endcase
            end
            if (burst_left > 0)
                burst_left--;
            else if (!quiet && $urandom_range(0, 99) < stall_percent)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(1, 10) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Presents one word from a falling edge and holds it until the filter
    // takes it. The caller is back at a falling edge on return. Valid is left
    // high so that back-to-back words need no second assignment in one step;
    // a random gap lowers it before the next word.
    task automatic send_word(input msc_op_t op, input logic [4:0] idx,
                             input logic [31:0] members, input logic [31:0] mask);
        msc_in_t w;
        w.op = op;
        w.entry_index = idx;
        w.entry_members = members;
        w.candidate_mask = mask;
        in_data <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        cover_tracker.note_word(w);
        words_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < gap_percent)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Holds the input side idle until every predicted result has arrived,
    // then lets the last pass inside the filter settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (cover_tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // tree_count is only rewritten with the filter idle. The APB write has a
    // setup phase and an access phase and lands at the edge where pready is high.
    task automatic write_tree_count(input logic [5:0] value);
        drain_results();
        paddr <= 3'(4 * MSC_REG_TREE_COUNT);
        pwdata <= {26'b0, value};
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        cover_tracker.set_tree_count(value);
        config_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // A noise word: anything the fields allow, the unused op included.
    task automatic send_noise();
        send_word(msc_op_t'($urandom_range(0, 3)), 5'($urandom), $urandom, $urandom);
    endtask

    // A well-formed search: a small family in a random window of the store,
    // then every non-empty selection of that window in order of size. Now and
    // then a stray word breaks the sequence, which the prediction follows anyway.
    task automatic run_enumeration();
        int          width;
        int          base;
        int          size;
        int          sel;
        int          i;
        logic [31:0] uni;
        logic [31:0] members;
        logic [5:0]  count_value;
        width = $urandom_range(3, 6);
        base = $urandom_range(0, 32 - width);
        case ($urandom_range(0, 9)) inside
            [0:4]: count_value = 6'($urandom_range(1, 8));
            [5:7]: count_value = 6'($urandom_range(9, 32));
            8: count_value = 6'd32;
            default: count_value = 6'($urandom_range(0, 63));
        endcase
        write_tree_count(count_value);
        uni = cover_tracker.universe_bits();
        send_word(OP_CLEAR, 5'($urandom), $urandom, $urandom);
        for (i = 0; i < width; i++)
        begin
            case ($urandom_range(0, 2))
                0: members = $urandom & $urandom;
                1: members = $urandom;
                default: members = $urandom | $urandom;
            endcase
            // Mostly within the universe; a stray high bit spoils any cover that selects the entry.
            if ($urandom_range(0, 7) != 0)
                members &= uni;
            send_word(OP_LOAD, 5'(base + i), members, $urandom);
        end
        for (size = 1; size <= width; size++)
            for (sel = 1; sel < (1 << width); sel++)
                if ($countones(sel) == size)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        case ($urandom_range(0, 3))
                            0: send_word(OP_NONE, 5'($urandom), $urandom, $urandom);
                            1: send_word(OP_CLEAR, 5'($urandom), $urandom, $urandom);
                            2: send_word(OP_TEST, 5'($urandom), $urandom, $urandom);
                            default: send_word(OP_LOAD,
                                5'(base + width + $urandom_range(0, 31 - width)),
                                $urandom, $urandom);
                        endcase
                    end
                    send_word(OP_TEST, 5'($urandom), $urandom, 32'(sel) << base);
                end
    endtask

    // Overflows the found store: with a two-element universe, every pair of
    // one low-bit entry and one high-bit entry is a minimal cover, 80 of them
    // in all, tested in random order after a few single-entry candidates.
    task automatic run_store_overflow();
        logic [31:0] pairs [$];
        logic [31:0] swap;
        int          i;
        int          j;
        write_tree_count(6'd2);
        send_word(OP_CLEAR, 5'($urandom), $urandom, $urandom);
        for (i = 0; i < 18; i++)
            send_word(OP_LOAD, 5'(i), (i < 8) ? 32'h1 : 32'h2, $urandom);
        for (i = 0; i < 3; i++)
            send_word(OP_TEST, 5'($urandom), $urandom, 32'h1 << $urandom_range(0, 17));
        for (i = 0; i < 8; i++)
            for (j = 8; j < 18; j++)
                pairs.insert(pairs.size(), (32'h1 << i) | (32'h1 << j));
        for (i = pairs.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap = pairs[i];
            pairs[i] = pairs[j];
            pairs[j] = swap;
        end
        foreach (pairs[k])
            send_word(OP_TEST, 5'($urandom), $urandom, pairs[k]);
        for (i = 0; i < 4; i++)
            send_word(OP_TEST, 5'($urandom), $urandom,
                      pairs[i] | (32'h1 << $urandom_range(0, 17)));
    endtask

    initial
    begin
        int episode;
        int pick;
        int i;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Right after reset the family is empty and the
        // universe is one element, so nothing covers yet.
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0);
        send_word(OP_NONE, 5'h1f, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_LOAD, 5'd0, 32'h0000_0001, 32'h0);
        send_word(OP_LOAD, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0001);
        // Bits beyond the universe in the union spoil the cover.
        send_word(OP_TEST, 5'd0, 32'h0, 32'h8000_0000);
        // Covers, but holds the stored cover, so it is not minimal.
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0003);
        send_word(OP_CLEAR, 5'd0, 32'h0, 32'h0);

        // Empty universe: only an empty union covers, and the empty
        // selection, once stored, lies inside every later candidate.
        write_tree_count(6'd0);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0002);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0);

        // An oversized tree_count saturates to the full 32-bit universe.
        write_tree_count(6'd63);
        send_word(OP_TEST, 5'd0, 32'h0, 32'hffff_ffff);
        send_word(OP_CLEAR, 5'd0, 32'h0, 32'h0);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h8000_0000);
        send_word(OP_TEST, 5'd0, 32'h0, 32'hffff_ffff);

        write_tree_count(6'd32);
        send_word(OP_LOAD, 5'd5, 32'haaaa_aaaa, 32'h0);
        send_word(OP_LOAD, 5'd6, 32'h5555_5555, 32'h0);
        send_word(OP_CLEAR, 5'd0, 32'h0, 32'h0);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0060);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0020);
        write_tree_count(6'd33);
        send_word(OP_TEST, 5'd0, 32'h0, 32'h0000_0060);
        send_word(OP_LOAD, 5'd31, 32'h0, 32'h0);
        send_word(OP_NONE, 5'h0, 32'h0, 32'h0);

        // Random part: mostly well-formed searches, with the found store
        // overflowed twice and short runs of noise in between. The idle
        // rate of the input side is redrawn per phase.
        episode = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            quiet = (words_sent + 100 >= RANDOM_WORDS);
            case ($urandom_range(0, 2))
                0: gap_percent = 0;
                1: gap_percent = 10;
                default: gap_percent = 35;
            endcase
            pick = $urandom_range(0, 9);
            if (episode == 3 || episode == 14)
                run_store_overflow();
            else if (pick < 2)
            begin
                for (i = $urandom_range(10, 25); i > 0; i--)
                    send_noise();
            end
            else
                run_enumeration();
            episode++;
        end

        // Closing part: the last tree_count is the reset value again.
        write_tree_count(6'd1);
        quiet = 1'b1;
        for (i = 0; i < 20; i++)
            send_word(OP_TEST, 5'($urandom), $urandom, $urandom);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d words in %0d cycles with %0d tree_count writes: %0d tests, %0d covers",
                 words_sent, cycle_count, config_writes,
                 cover_tracker.tests_noted, cover_tracker.covers_noted);
        $display("Stored %0d minimal covers, %0d refused with the found store full",
                 cover_tracker.stored_noted, cover_tracker.full_noted);
        $display("Checked %0d result words", cover_tracker.results_checked);
        if (cover_tracker.mismatches == 0 && cover_tracker.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
